// File: hw/rtl/skl_pkg.sv
// Shared types and constants for the sorted key list engine.
package skl_pkg;

  localparam int KEY_W  = 27;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 3;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_LIST_ASC  = 2'd2,
    CMD_LIST_DESC = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_ENTRY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_FIN,
    ST_REM,
    ST_LST_RD,
    ST_LST_DATA,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

// File: hw/rtl/skl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module skl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/sorted_key_list_engine_unit.sv
// Top level of the sorted key list engine: command sequencer around the record RAM.
//
// The block keeps up to CAPACITY records (key and name tag) in ascending key
// order inside one simple dual-port RAM. Commands arrive on the input channel
// (in_valid_i / in_ready_o) and results leave on the output channel
// (out_valid_o / out_ready_i); each transfer happens when valid and ready are
// both high. One command is worked on at a time, and in_ready_o is high only
// while the sequencer is idle.
//
// Insert walks downward from the top entry, moving every entry whose key is
// not below the new key up by one slot, one entry per cycle, then writes the
// new record. Remove walks upward from slot zero, closing the gap behind the
// first matching key, also one entry per cycle. Both give a single result. A
// list command reads each entry in turn once the output register is free, then
// loads it into the output register.
//
// Results sit in an output register; the sequencer simply waits there while
// the receiver stalls, and a new command can be taken while the final result
// of the previous one is still waiting. Reset empties the table at once by
// clearing the entry count; the RAM contents need no clearing.
module sorted_key_list_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [skl_pkg::CMD_W-1:0]   command_i,
  input  logic [skl_pkg::KEY_W-1:0]   key_i,
  input  logic [skl_pkg::TAG_W-1:0]   name_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [skl_pkg::STAT_W-1:0]  status_o,
  output logic [skl_pkg::KEY_W-1:0]   entry_key_o,
  output logic [skl_pkg::TAG_W-1:0]   entry_tag_o,
  output logic                        last_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  skl_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    last_idx;
  logic [skl_pkg::KEY_W-1:0] key_q, key_d;
  logic [skl_pkg::TAG_W-1:0] tag_q, tag_d;
  logic             asc_q, asc_d;
  logic             found_q, found_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    lcnt_q, lcnt_d;
  skl_pkg::status_e rsp_q, rsp_d;

  logic             out_valid_q, out_valid_d;
  skl_pkg::status_e out_st_q, out_st_d;
  logic [skl_pkg::KEY_W-1:0] out_key_q, out_key_d;
  logic [skl_pkg::TAG_W-1:0] out_tag_q, out_tag_d;
  logic             out_last_q, out_last_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  skl_pkg::entry_t  ram_wdata, ram_rdata;
  logic             out_free;
  logic             key_hit;

  skl_ram #(
    .WIDTH($bits(skl_pkg::entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cnt_m1   = cnt_q - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign key_hit  = (ram_rdata.key == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skl_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    tag_q      <= tag_d;
    asc_q      <= asc_d;
    found_q    <= found_d;
    pidx_q     <= pidx_d;
    pos_q      <= pos_d;
    ptr_q      <= ptr_d;
    lcnt_q     <= lcnt_d;
    rsp_q      <= rsp_d;
    out_st_q   <= out_st_d;
    out_key_q  <= out_key_d;
    out_tag_q  <= out_tag_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    tag_d       = tag_q;
    asc_d       = asc_q;
    found_d     = found_q;
    pidx_d      = pidx_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    lcnt_d      = lcnt_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_key_d   = out_key_q;
    out_tag_d   = out_tag_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = pidx_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = pidx_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      skl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d = key_i;
          tag_d = name_tag_i;
          unique case (skl_pkg::cmd_e'(command_i))
            skl_pkg::CMD_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                rsp_d   = skl_pkg::STAT_FULL;
                state_d = skl_pkg::ST_RESP;
              end else if (cnt_q == '0) begin
                pos_d   = '0;
                state_d = skl_pkg::ST_INS_FIN;
              end else begin
                // Start the downward walk at the top entry.
                ram_re    = 1'b1;
                ram_raddr = last_idx;
                pidx_d    = last_idx;
                state_d   = skl_pkg::ST_INS;
              end
            end
            skl_pkg::CMD_REMOVE: begin
              if (cnt_q == '0) begin
                rsp_d   = skl_pkg::STAT_NOT_FOUND;
                state_d = skl_pkg::ST_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                pidx_d    = '0;
                found_d   = 1'b0;
                state_d   = skl_pkg::ST_REM;
              end
            end
            skl_pkg::CMD_LIST_ASC, skl_pkg::CMD_LIST_DESC: begin
              if (cnt_q == '0) begin
                rsp_d   = skl_pkg::STAT_EMPTY;
                state_d = skl_pkg::ST_RESP;
              end else begin
                asc_d   = (skl_pkg::cmd_e'(command_i) == skl_pkg::CMD_LIST_ASC);
                ptr_d   = (skl_pkg::cmd_e'(command_i) == skl_pkg::CMD_LIST_ASC) ?
                          '0 : last_idx;
                lcnt_d  = '0;
                state_d = skl_pkg::ST_LST_RD;
              end
            end
          endcase
        end
      end

      skl_pkg::ST_INS: begin
        // Read data belongs to slot pidx_q; the next slot down is read meanwhile.
        if (ram_rdata.key >= key_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q + AW'(1);
          if (pidx_q == '0) begin
            pos_d   = '0;
            state_d = skl_pkg::ST_INS_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pidx_q - AW'(1);
            pidx_d    = pidx_q - AW'(1);
          end
        end else begin
          pos_d   = pidx_q + AW'(1);
          state_d = skl_pkg::ST_INS_FIN;
        end
      end

      skl_pkg::ST_INS_FIN: begin
        ram_we        = 1'b1;
        ram_waddr     = pos_q;
        ram_wdata.key = key_q;
        ram_wdata.tag = tag_q;
        cnt_d         = cnt_q + CW'(1);
        rsp_d         = skl_pkg::STAT_DONE;
        state_d       = skl_pkg::ST_RESP;
      end

      skl_pkg::ST_REM: begin
        // Once the match is behind us, every later entry moves down one slot.
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - AW'(1);
        end else if (key_hit) begin
          found_d = 1'b1;
        end
        if (pidx_q == last_idx) begin
          if (found_q || key_hit) begin
            cnt_d = cnt_m1;
            rsp_d = skl_pkg::STAT_DONE;
          end else begin
            rsp_d = skl_pkg::STAT_NOT_FOUND;
          end
          state_d = skl_pkg::ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = pidx_q + AW'(1);
          pidx_d    = pidx_q + AW'(1);
        end
      end

      skl_pkg::ST_LST_RD: begin
        // Only read once the output register is sure to be free next cycle.
        if (out_free) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          state_d   = skl_pkg::ST_LST_DATA;
        end
      end

      skl_pkg::ST_LST_DATA: begin
        out_valid_d = 1'b1;
        out_st_d    = skl_pkg::STAT_ENTRY;
        out_key_d   = ram_rdata.key;
        out_tag_d   = ram_rdata.tag;
        out_last_d  = (lcnt_q == cnt_m1);
        if (lcnt_q == cnt_m1) begin
          state_d = skl_pkg::ST_IDLE;
        end else begin
          ptr_d   = asc_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
          lcnt_d  = lcnt_q + CW'(1);
          state_d = skl_pkg::ST_LST_RD;
        end
      end

      skl_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = rsp_q;
          out_key_d   = '0;
          out_tag_d   = '0;
          out_last_d  = 1'b1;
          state_d     = skl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = skl_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign entry_key_o = out_key_q;
  assign entry_tag_o = out_tag_q;
  assign last_o      = out_last_q;

endmodule
